/* sv/frgrp_pkg.sv */
`default_nettype none
package frgrp_pkg;

	localparam int MAX_PARTICLES = 64;
	localparam int COORD_BITS    = 16;

	localparam int IN_W   = 16;
	localparam int RAD_W  = 16;
	localparam int IDXO_W = 6;
	localparam int LBLO_W = 7;
	localparam int MULO_W = 6;

	localparam int IDX_W   = $clog2(MAX_PARTICLES);
	localparam int CNT_W   = $clog2(MAX_PARTICLES + 1);
	localparam int MULTI_W = $clog2(MAX_PARTICLES / 2 + 1);
	localparam int EXT_W   = (COORD_BITS > IN_W) ? COORD_BITS : IN_W;
	localparam int AD_W    = COORD_BITS;
	localparam int SQ_W    = 2 * COORD_BITS;
	localparam int SUM_W   = SQ_W + 2;
	localparam int R2_W    = 2 * RAD_W;
	localparam int CMP_W   = (SUM_W > R2_W) ? SUM_W : R2_W;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
	} pos_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
	} dist_tag_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
		logic             link;
	} dist_res_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SEED,
		ST_JCHK,
		ST_JREAD,
		ST_SCAN,
		ST_DRAIN,
		ST_ORD,
		ST_OWAIT,
		ST_OHOLD
	} state_t;

	function automatic logic signed [COORD_BITS-1:0] to_coord(input logic signed [IN_W-1:0] v);
		logic signed [EXT_W-1:0] e;
		e = EXT_W'(v);
		return e[COORD_BITS-1:0];
	endfunction

	function automatic logic [AD_W-1:0] abs_diff(input logic signed [COORD_BITS-1:0] a,
			input logic signed [COORD_BITS-1:0] b);
		logic signed [COORD_BITS:0] d;
		logic [COORD_BITS:0]        m;
		d = (COORD_BITS + 1)'(a) - (COORD_BITS + 1)'(b);
		m = d[COORD_BITS] ? -d : d;
		return m[AD_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* sv/frgrp_if.sv */
`default_nettype none
interface frgrp_item_if;
	import frgrp_pkg::*;
	logic                   valid;
	logic                   ready;
	logic signed [IN_W-1:0] pos_x;
	logic signed [IN_W-1:0] pos_y;
	logic signed [IN_W-1:0] pos_z;
	logic                   last_particle;
	modport source(output valid, pos_x, pos_y, pos_z, last_particle, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, last_particle, output ready);
endinterface

interface frgrp_result_if;
	import frgrp_pkg::*;
	logic              valid;
	logic              ready;
	logic [IDXO_W-1:0] particle_index;
	logic [LBLO_W-1:0] group_label;
	logic [LBLO_W-1:0] group_count;
	logic [MULO_W-1:0] multi_member_groups;
	logic              last_result;
	modport source(output valid, particle_index, group_label, group_count,
		multi_member_groups, last_result, input ready);
	modport sink(input valid, particle_index, group_label, group_count,
		multi_member_groups, last_result, output ready);
endinterface

interface frgrp_cfg_if;
	import frgrp_pkg::*;
	logic             valid;
	logic             ready;
	logic [RAD_W-1:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

/* sv/frgrp_dist.sv */
`default_nettype none
module frgrp_dist (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [frgrp_pkg::R2_W-1:0]  r2,
	input  frgrp_pkg::pos_t             pos_a,
	input  frgrp_pkg::pos_t             pos_b,
	input  frgrp_pkg::dist_tag_t        tag,
	output frgrp_pkg::dist_res_t        res,
	output logic                        busy
);
	import frgrp_pkg::*;

	dist_tag_t       tag_s2, tag_s3;
	dist_res_t       res_s4;
	logic [AD_W-1:0] adx_s2, ady_s2, adz_s2;
	logic [SQ_W-1:0] sqx_s3, sqy_s3, sqz_s3;
	logic [SUM_W-1:0] sum;

	always_comb begin
		sum = SUM_W'(sqx_s3) + SUM_W'(sqy_s3) + SUM_W'(sqz_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			res_s4 <= '0;
		end else begin
			tag_s2      <= tag;
			tag_s3      <= tag_s2;
			res_s4.valid <= tag_s3.valid;
			res_s4.idx   <= tag_s3.idx;
			res_s4.link  <= (CMP_W'(sum) <= CMP_W'(r2));
		end
	end

	always_ff @(posedge clk) begin
		adx_s2 <= abs_diff(pos_a.x, pos_b.x);
		ady_s2 <= abs_diff(pos_a.y, pos_b.y);
		adz_s2 <= abs_diff(pos_a.z, pos_b.z);
		sqx_s3 <= SQ_W'(adx_s2) * SQ_W'(adx_s2);
		sqy_s3 <= SQ_W'(ady_s2) * SQ_W'(ady_s2);
		sqz_s3 <= SQ_W'(adz_s2) * SQ_W'(adz_s2);
	end

	assign res  = res_s4;
	assign busy = tag_s2.valid | tag_s3.valid | res_s4.valid;

endmodule
`default_nettype wire

/* sv/friends_of_friends_grouping_unit.sv */
`default_nettype none
// Loading: one particle beat per cycle, no result until the beat marked last.
// Grouping: per seed, each group member reads its position, then every index after
// the seed goes through the distance pipeline and is drained; other indices are
// skipped; sweeps repeat until no member is added. Position memory: single read port.
// Output: ORD reads the label, OWAIT raises valid, OHOLD holds it until ready.
// Reset clears all control state at once; memories need no clearing pass.
module friends_of_friends_grouping_unit (
	input  logic         clk,
	input  logic         arst_n,
	frgrp_cfg_if.sink    cfg,
	frgrp_item_if.sink   items,
	frgrp_result_if.source results
);
	import frgrp_pkg::*;

	state_t state_q, state_d;

	logic [RAD_W-1:0]         radius_q;
	logic [R2_W-1:0]          r2_q;
	logic [CNT_W-1:0]         cnt_q, i_q, j_q, l_q, grp_q;
	logic [IDX_W-1:0]         k_q;
	logic [MULTI_W-1:0]       multi_q;
	logic                     grew_q, seed_grew_q;
	logic [MAX_PARTICLES-1:0] done_q, ingrp_q;

	pos_t             pos_mem [MAX_PARTICLES];
	pos_t             pos_rd, pos_j_q;
	logic [CNT_W-1:0] lbl_mem [MAX_PARTICLES];
	logic [CNT_W-1:0] lbl_rd;

	dist_tag_t tag_s1;
	dist_res_t res;
	logic      dist_busy;

	logic             item_beat, pos_we, pos_re, lbl_we, lbl_re, issue, items_ready;
	logic [IDX_W-1:0] pos_raddr, lbl_waddr;
	logic [CNT_W-1:0] lbl_wdata;
	logic [IDX_W-1:0] i_idx, j_idx, l_idx;
	logic             i_end, j_end, l_end, k_last, link_hit, seed_new, drained, room;

	assign i_idx    = i_q[IDX_W-1:0];
	assign j_idx    = j_q[IDX_W-1:0];
	assign l_idx    = l_q[IDX_W-1:0];
	assign i_end    = (i_q == cnt_q);
	assign j_end    = (j_q == cnt_q);
	assign l_end    = (l_q == cnt_q);
	assign k_last   = (CNT_W'(k_q) == cnt_q - CNT_W'(1));
	assign room     = (cnt_q < CNT_W'(MAX_PARTICLES));
	assign item_beat = items.valid && items_ready;
	assign link_hit = res.valid && res.link && !done_q[res.idx];
	assign seed_new = (state_q == ST_SEED) && !i_end && !done_q[i_idx];
	assign drained  = !tag_s1.valid && !dist_busy;

	assign items.ready = items_ready;
	assign cfg.ready   = 1'b1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (item_beat && items.last_particle) state_d = ST_SEED;
			end
			ST_SEED: begin
				if (i_end) state_d = ST_ORD;
				else if (!done_q[i_idx]) state_d = ST_JCHK;
			end
			ST_JCHK: begin
				if (j_end) begin
					if (!grew_q) state_d = ST_SEED;
				end else if (ingrp_q[j_idx]) begin
					state_d = ST_JREAD;
				end
			end
			ST_JREAD: state_d = ST_SCAN;
			ST_SCAN: begin
				if (l_end) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (drained) state_d = ST_JCHK;
			end
			ST_ORD:   state_d = ST_OWAIT;
			ST_OWAIT: state_d = ST_OHOLD;
			ST_OHOLD: begin
				if (results.ready) state_d = k_last ? ST_LOAD : ST_ORD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		items_ready = 1'b0;
		pos_re      = 1'b0;
		pos_raddr   = j_idx;
		issue       = 1'b0;
		lbl_re      = 1'b0;
		case (state_q)
			ST_LOAD: items_ready = 1'b1;
			ST_JCHK: pos_re = !j_end && ingrp_q[j_idx];
			ST_SCAN: begin
				pos_re    = !l_end;
				pos_raddr = l_idx;
				issue     = !l_end;
			end
			ST_ORD: lbl_re = 1'b1;
			default: begin
			end
		endcase
	end

	assign pos_we    = item_beat && room;
	assign lbl_we    = seed_new || link_hit;
	assign lbl_waddr = link_hit ? res.idx : i_idx;
	assign lbl_wdata = link_hit ? grp_q : grp_q + CNT_W'(1);

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[cnt_q[IDX_W-1:0]] <= '{x: to_coord(items.pos_x),
				y: to_coord(items.pos_y), z: to_coord(items.pos_z)};
		end
		if (pos_re) pos_rd <= pos_mem[pos_raddr];
	end

	always_ff @(posedge clk) begin
		if (lbl_we) lbl_mem[lbl_waddr] <= lbl_wdata;
		if (lbl_re) lbl_rd <= lbl_mem[k_q];
	end

	frgrp_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.r2     (r2_q),
		.pos_a  (pos_j_q),
		.pos_b  (pos_rd),
		.tag    (tag_s1),
		.res    (res),
		.busy   (dist_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			radius_q      <= '0;
			cnt_q         <= '0;
			i_q           <= '0;
			j_q           <= '0;
			l_q           <= '0;
			k_q           <= '0;
			grp_q         <= '0;
			multi_q       <= '0;
			grew_q        <= 1'b0;
			seed_grew_q   <= 1'b0;
			done_q        <= '0;
			ingrp_q       <= '0;
			tag_s1        <= '0;
			results.valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			tag_s1.valid <= issue;
			tag_s1.idx   <= l_idx;
			if (cfg.valid) radius_q <= cfg.data;
			if (link_hit) begin
				done_q[res.idx]  <= 1'b1;
				ingrp_q[res.idx] <= 1'b1;
				grew_q           <= 1'b1;
				seed_grew_q      <= 1'b1;
			end
			case (state_q)
				ST_LOAD: begin
					if (pos_we) cnt_q <= cnt_q + CNT_W'(1);
					if (item_beat && items.last_particle) i_q <= '0;
				end
				ST_SEED: begin
					if (i_end) begin
						k_q <= '0;
					end else if (done_q[i_idx]) begin
						i_q <= i_q + CNT_W'(1);
					end else begin
						done_q[i_idx] <= 1'b1;
						ingrp_q        <= '0;
						ingrp_q[i_idx] <= 1'b1;
						grp_q          <= grp_q + CNT_W'(1);
						j_q            <= i_q;
						grew_q         <= 1'b0;
						seed_grew_q    <= 1'b0;
					end
				end
				ST_JCHK: begin
					if (j_end) begin
						if (grew_q) begin
							j_q    <= i_q;
							grew_q <= 1'b0;
						end else begin
							if (seed_grew_q) multi_q <= multi_q + MULTI_W'(1);
							i_q <= i_q + CNT_W'(1);
						end
					end else if (!ingrp_q[j_idx]) begin
						j_q <= j_q + CNT_W'(1);
					end
				end
				ST_JREAD: l_q <= i_q + CNT_W'(1);
				ST_SCAN: begin
					if (!l_end) l_q <= l_q + CNT_W'(1);
				end
				ST_DRAIN: begin
					if (drained) j_q <= j_q + CNT_W'(1);
				end
				ST_OWAIT: results.valid <= 1'b1;
				ST_OHOLD: begin
					if (results.ready) begin
						results.valid <= 1'b0;
						if (k_last) begin
							cnt_q   <= '0;
							grp_q   <= '0;
							multi_q <= '0;
							done_q  <= '0;
							ingrp_q <= '0;
						end else begin
							k_q <= k_q + IDX_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		r2_q <= R2_W'(radius_q) * R2_W'(radius_q);
		if (state_q == ST_JREAD) pos_j_q <= pos_rd;
		if (state_q == ST_OWAIT) begin
			results.particle_index      <= IDXO_W'(k_q);
			results.group_label         <= LBLO_W'(lbl_rd);
			results.group_count         <= LBLO_W'(grp_q);
			results.multi_member_groups <= MULO_W'(multi_q);
			results.last_result         <= k_last;
		end
	end

endmodule
`default_nettype wire
